// ===== hw/rtl/segment_rect_intersect_core_defines.svh =====
// assertion macros used by the checker file
`ifndef SEGMENT_RECT_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_RECT_INTERSECT_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SRI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define SRI_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sri_pkg.sv =====
// shared types, constants and width helper for the segment/rectangle core
package sri_pkg;

  localparam int unsigned RECT_WIDTH          = 12;
  localparam int unsigned DEF_COORD_WIDTH     = 16;
  localparam int unsigned DEF_COORD_FRAC_BITS = 4;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_e;

  typedef struct packed {
    logic  hit;
    edge_e edge_id;
    logic  along_x;
    logic  neg;
  } sri_ctrl_t;

  // internal signed width: holds every coordinate, scaled edge and difference
  function automatic int unsigned ext_width(int unsigned cw, int unsigned fb);
    int unsigned m;
    m = (cw > RECT_WIDTH + fb) ? cw : RECT_WIDTH + fb;
    return m + 2;
  endfunction

endpackage

// ===== hw/rtl/sri_front.sv =====
// front end: edge tests for every rectangle edge and first-hit selection
module sri_front #(
  parameter int unsigned COORD_WIDTH     = sri_pkg::DEF_COORD_WIDTH,
  parameter int unsigned COORD_FRAC_BITS = sri_pkg::DEF_COORD_FRAC_BITS,
  localparam int unsigned EW = sri_pkg::ext_width(COORD_WIDTH, COORD_FRAC_BITS),
  localparam int unsigned PW = 2 * EW
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   en_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_x0_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_y0_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_x1_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_y1_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0]  rect_left_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0]  rect_top_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0]  rect_right_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0]  rect_bottom_i,
  output logic                                   out_valid_o,
  output sri_pkg::sri_ctrl_t                     out_ctrl_o,
  output logic [PW-1:0]                          out_num_o,
  output logic [EW-1:0]                          out_den_o,
  output logic signed [EW-1:0]                   out_a0_o,
  output logic signed [EW-1:0]                   out_fix_o
);
  import sri_pkg::*;

  logic signed [EW-1:0] x0, y0, x1, y1, rl, rt, rr, rb;
  logic signed [EW-1:0] c0 [4], c1 [4], a0 [4], a1 [4], e [4], b0 [4], b1 [4];

  // stage 1
  logic                 v1_q;
  logic                 ok1_d [4], ok1_q [4];
  logic signed [EW-1:0] da1_d [4], da1_q [4];
  logic signed [EW-1:0] n1_d [4], n1_q [4];
  logic signed [EW-1:0] d1_d [4], d1_q [4];
  logic signed [EW-1:0] loa1_d [4], loa1_q [4];
  logic signed [EW-1:0] hia1_d [4], hia1_q [4];
  logic signed [EW-1:0] a01_q [4], e1_q [4];

  // stage 2
  logic                 v2_q;
  logic                 ok2_q [4];
  logic signed [PW-1:0] prod2_q [4], plo2_q [4], phi2_q [4];
  logic                 neg2_q [4];
  logic signed [EW-1:0] d2_q [4], a02_q [4], e2_q [4];

  logic                 hitk [4];

  assign x0 = EW'(seg_x0_i);
  assign y0 = EW'(seg_y0_i);
  assign x1 = EW'(seg_x1_i);
  assign y1 = EW'(seg_y1_i);
  assign rl = EW'(rect_left_i)   <<< COORD_FRAC_BITS;
  assign rt = EW'(rect_top_i)    <<< COORD_FRAC_BITS;
  assign rr = EW'(rect_right_i)  <<< COORD_FRAC_BITS;
  assign rb = EW'(rect_bottom_i) <<< COORD_FRAC_BITS;

  // edges in priority order: top, right, bottom, left
  always_comb begin
    c0[0] = y0; c1[0] = y1; a0[0] = x0; a1[0] = x1; e[0] = rt; b0[0] = rl; b1[0] = rr;
    c0[1] = x0; c1[1] = x1; a0[1] = y0; a1[1] = y1; e[1] = rr; b0[1] = rt; b1[1] = rb;
    c0[2] = y0; c1[2] = y1; a0[2] = x0; a1[2] = x1; e[2] = rb; b0[2] = rl; b1[2] = rr;
    c0[3] = x0; c1[3] = x1; a0[3] = y0; a1[3] = y1; e[3] = rl; b0[3] = rt; b1[3] = rb;
  end

  for (genvar k = 0; k < 4; k++) begin : g_edge
    logic signed [EW-1:0] dc, lo, hi;

    always_comb begin
      dc        = c1[k] - c0[k];
      da1_d[k]  = a1[k] - a0[k];
      d1_d[k]   = dc[EW-1] ? -dc : dc;
      n1_d[k]   = dc[EW-1] ? (c0[k] - e[k]) : (e[k] - c0[k]);
      lo        = (b0[k] < b1[k]) ? b0[k] : b1[k];
      hi        = (b0[k] < b1[k]) ? b1[k] : b0[k];
      loa1_d[k] = lo - a0[k];
      hia1_d[k] = hi - a0[k];
      ok1_d[k]  = (dc != '0) && (b0[k] != b1[k]) && !n1_d[k][EW-1] && (n1_d[k] <= d1_d[k]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ok1_q[k]   <= ok1_d[k];
        da1_q[k]   <= da1_d[k];
        n1_q[k]    <= n1_d[k];
        d1_q[k]    <= d1_d[k];
        loa1_q[k]  <= loa1_d[k];
        hia1_q[k]  <= hia1_d[k];
        a01_q[k]   <= a0[k];
        e1_q[k]    <= e[k];
        ok2_q[k]   <= ok1_q[k];
        prod2_q[k] <= PW'(da1_q[k]) * PW'(n1_q[k]);
        plo2_q[k]  <= PW'(loa1_q[k]) * PW'(d1_q[k]);
        phi2_q[k]  <= PW'(hia1_q[k]) * PW'(d1_q[k]);
        neg2_q[k]  <= da1_q[k][EW-1];
        d2_q[k]    <= d1_q[k];
        a02_q[k]   <= a01_q[k];
        e2_q[k]    <= e1_q[k];
      end
    end

    assign hitk[k] = ok2_q[k] && !(prod2_q[k] < plo2_q[k]) && !(phi2_q[k] < prod2_q[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // first edge hit wins
  always_comb begin
    logic [1:0]           sel;
    logic signed [PW-1:0] p;
    sel = 2'd0;
    if (hitk[0])      sel = 2'd0;
    else if (hitk[1]) sel = 2'd1;
    else if (hitk[2]) sel = 2'd2;
    else if (hitk[3]) sel = 2'd3;
    p = prod2_q[sel];
    out_ctrl_o.hit     = hitk[0] | hitk[1] | hitk[2] | hitk[3];
    out_ctrl_o.edge_id = out_ctrl_o.hit ? edge_e'(sel) : EDGE_TOP;
    out_ctrl_o.along_x = ~sel[0];
    out_ctrl_o.neg     = neg2_q[sel];
    out_num_o          = p[PW-1] ? PW'(-p) : PW'(p);
    out_den_o          = d2_q[sel];
    out_a0_o           = a02_q[sel];
    out_fix_o          = e2_q[sel];
  end

  assign out_valid_o = v2_q;

endmodule

// ===== hw/rtl/sri_fifo.sv =====
// two-entry queue between front end and divider back end, drains every cycle
module sri_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  output logic          out_valid_o,
  output logic [DW-1:0] data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign full_o      = (cnt_q == 2'd2);
  assign push        = push_i && !full_o;
  assign pop         = (cnt_q != 2'd0);
  assign out_valid_o = pop;
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop)      cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/sri_back.sv =====
// back end: pipelined restoring divider, one quotient bit per stage, then point assembly
module sri_back #(
  parameter int unsigned COORD_WIDTH     = sri_pkg::DEF_COORD_WIDTH,
  parameter int unsigned COORD_FRAC_BITS = sri_pkg::DEF_COORD_FRAC_BITS,
  localparam int unsigned EW = sri_pkg::ext_width(COORD_WIDTH, COORD_FRAC_BITS),
  localparam int unsigned PW = 2 * EW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  sri_pkg::sri_ctrl_t            in_ctrl_i,
  input  logic [PW-1:0]                 in_num_i,
  input  logic [EW-1:0]                 in_den_i,
  input  logic signed [EW-1:0]          in_a0_i,
  input  logic signed [EW-1:0]          in_fix_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [1:0]                    edge_hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o
);
  import sri_pkg::*;

  logic                 sv_q   [EW];
  sri_ctrl_t            sctl_q [EW];
  logic [PW-1:0]        snum_q [EW];
  logic [EW-1:0]        sden_q [EW];
  logic signed [EW-1:0] sa0_q  [EW], sfix_q [EW];
  logic [EW-1:0]        srem_q [EW], sq_q [EW];

  for (genvar j = 0; j < EW; j++) begin : g_stage
    localparam int unsigned BI = EW - 1 - j;
    logic                 iv;
    sri_ctrl_t            ictl;
    logic [PW-1:0]        inum;
    logic [EW-1:0]        iden, irem, iq;
    logic signed [EW-1:0] ia0, ifix;
    logic [EW:0]          t, diff;
    logic                 ge;

    if (j == 0) begin : g_head
      assign iv   = in_valid_i;
      assign ictl = in_ctrl_i;
      assign inum = in_num_i;
      assign iden = in_den_i;
      assign ia0  = in_a0_i;
      assign ifix = in_fix_i;
      assign irem = in_num_i[PW-1:EW];
      assign iq   = '0;
    end else begin : g_body
      assign iv   = sv_q[j-1];
      assign ictl = sctl_q[j-1];
      assign inum = snum_q[j-1];
      assign iden = sden_q[j-1];
      assign ia0  = sa0_q[j-1];
      assign ifix = sfix_q[j-1];
      assign irem = srem_q[j-1];
      assign iq   = sq_q[j-1];
    end

    assign t    = {irem, inum[BI]};
    assign diff = t - {1'b0, iden};
    assign ge   = (t >= {1'b0, iden});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[j] <= 1'b0;
      else         sv_q[j] <= iv;
    end

    always_ff @(posedge clk_i) begin
      sctl_q[j] <= ictl;
      snum_q[j] <= inum;
      sden_q[j] <= iden;
      sa0_q[j]  <= ia0;
      sfix_q[j] <= ifix;
      srem_q[j] <= ge ? diff[EW-1:0] : t[EW-1:0];
      sq_q[j]   <= {iq[EW-2:0], ge};
    end
  end

  localparam int unsigned LS = EW - 1;

  logic signed [EW:0]          qs, along;
  logic signed [COORD_WIDTH-1:0] al_c, fx_c;
  logic                        done_q;
  logic                        hit_q;
  logic [1:0]                  edge_q;
  logic signed [COORD_WIDTH-1:0] x_q, y_q;

  assign qs    = $signed({1'b0, sq_q[LS]});
  assign along = (EW + 1)'(sa0_q[LS]) + (sctl_q[LS].neg ? -qs : qs);
  assign al_c  = along[COORD_WIDTH-1:0];
  assign fx_c  = sfix_q[LS][COORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= sv_q[LS];
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= sctl_q[LS].hit;
    edge_q <= sctl_q[LS].hit ? sctl_q[LS].edge_id : EDGE_TOP;
    if (!sctl_q[LS].hit) begin
      x_q <= '0;
      y_q <= '0;
    end else if (sctl_q[LS].along_x) begin
      x_q <= al_c;
      y_q <= fx_c;
    end else begin
      x_q <= fx_c;
      y_q <= al_c;
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign edge_hit_o = edge_q;
  assign hit_x_o    = x_q;
  assign hit_y_o    = y_q;

endmodule

// ===== hw/rtl/segment_rect_intersect_core.sv =====
// top level of the segment versus rectangle intersection core
// Takes one segment and one rectangle per clock when start_i is high and busy_o low,
// and returns one result per item, strobed by done_o for a single cycle. The internal
// width is EW = max(COORD_WIDTH, 12 + COORD_FRAC_BITS) + 2. Each item passes the edge
// tests and multiplies, the queue, and the quotient pipeline, which retires one bit per
// stage. Results cannot be held off; since the back end drains every cycle busy_o stays
// low in operation.
module segment_rect_intersect_core #(
  parameter int unsigned COORD_WIDTH     = sri_pkg::DEF_COORD_WIDTH,
  parameter int unsigned COORD_FRAC_BITS = sri_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [COORD_WIDTH-1:0]         seg_x0_i,
  input  logic signed [COORD_WIDTH-1:0]         seg_y0_i,
  input  logic signed [COORD_WIDTH-1:0]         seg_x1_i,
  input  logic signed [COORD_WIDTH-1:0]         seg_y1_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0] rect_left_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0] rect_top_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0] rect_right_i,
  input  logic signed [sri_pkg::RECT_WIDTH-1:0] rect_bottom_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [1:0]                            edge_hit_o,
  output logic signed [COORD_WIDTH-1:0]         hit_x_o,
  output logic signed [COORD_WIDTH-1:0]         hit_y_o
);
  import sri_pkg::*;

  localparam int unsigned EW  = ext_width(COORD_WIDTH, COORD_FRAC_BITS);
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned CTW = $bits(sri_ctrl_t);
  localparam int unsigned DW  = CTW + PW + 3 * EW;

  logic                 f_valid, q_full, q_valid;
  sri_ctrl_t            f_ctrl, q_ctrl;
  logic [PW-1:0]        f_num, q_num;
  logic [EW-1:0]        f_den, q_den;
  logic signed [EW-1:0] f_a0, f_fix, q_a0, q_fix;
  logic [DW-1:0]        q_wdata, q_rdata;

  assign busy_o = q_full;

  sri_front #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (start_i),
    .en_i         (!q_full),
    .seg_x0_i     (seg_x0_i),
    .seg_y0_i     (seg_y0_i),
    .seg_x1_i     (seg_x1_i),
    .seg_y1_i     (seg_y1_i),
    .rect_left_i  (rect_left_i),
    .rect_top_i   (rect_top_i),
    .rect_right_i (rect_right_i),
    .rect_bottom_i(rect_bottom_i),
    .out_valid_o  (f_valid),
    .out_ctrl_o   (f_ctrl),
    .out_num_o    (f_num),
    .out_den_o    (f_den),
    .out_a0_o     (f_a0),
    .out_fix_o    (f_fix)
  );

  assign q_wdata = {f_ctrl, f_num, f_den, f_a0, f_fix};

  sri_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_valid),
    .data_i     (q_wdata),
    .full_o     (q_full),
    .out_valid_o(q_valid),
    .data_o     (q_rdata)
  );

  assign {q_ctrl, q_num, q_den, q_a0, q_fix} = q_rdata;

  sri_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(q_valid),
    .in_ctrl_i (q_ctrl),
    .in_num_i  (q_num),
    .in_den_i  (q_den),
    .in_a0_i   (q_a0),
    .in_fix_i  (q_fix),
    .done_o    (done_o),
    .hit_o     (hit_o),
    .edge_hit_o(edge_hit_o),
    .hit_x_o   (hit_x_o),
    .hit_y_o   (hit_y_o)
  );

endmodule

// ===== hw/rtl/sri_checker.sv =====
// port-level checker for the intersection core and its bind
`include "segment_rect_intersect_core_defines.svh"

module sri_checker #(
  parameter int unsigned COORD_WIDTH     = sri_pkg::DEF_COORD_WIDTH,
  parameter int unsigned COORD_FRAC_BITS = sri_pkg::DEF_COORD_FRAC_BITS
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start_i,
  input logic                                  busy_o,
  input logic                                  done_o,
  input logic                                  hit_o,
  input logic [1:0]                            edge_hit_o,
  input logic signed [COORD_WIDTH-1:0]         hit_x_o,
  input logic signed [COORD_WIDTH-1:0]         hit_y_o
);
  import sri_pkg::*;

  localparam int unsigned LAT = ext_width(COORD_WIDTH, COORD_FRAC_BITS) + 4;

  logic acc;
  assign acc = rst_ni && start_i && !busy_o;

  // every accepted item comes out on done_o
  `SRI_ASSERT(a_item_out, clk_i, rst_ni, acc |-> ##LAT done_o, "accepted item not delivered")
  // and no result appears without an item behind it
  `SRI_ASSERT(a_no_phantom, clk_i, rst_ni, done_o |-> $past(acc, LAT), "result without item")
  `SRI_ASSERT(a_miss_zero, clk_i, rst_ni,
              (done_o && !hit_o) |-> (edge_hit_o == EDGE_TOP && hit_x_o == '0 && hit_y_o == '0),
              "miss result carries nonzero fields")
  `SRI_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o, "back end failed to drain")

endmodule

bind segment_rect_intersect_core sri_checker #(
  .COORD_WIDTH    (COORD_WIDTH),
  .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_sri_checker (.*);
